### hw/rtl/edd_pkg.sv
`timescale 1ns / 1ps

package edd_pkg;

  localparam int ErrBits  = 14;
  localparam int ErrMax   = 8191;
  localparam int ErrMin   = -8192;
  localparam int LevelBits = 12;
  localparam int RowWidthBits = 10;
  localparam int MinRowWidth  = 3;

  localparam logic [RowWidthBits-1:0] RowWidthReset   = 10'd512;
  localparam logic [LevelBits-1:0]    ThresholdReset  = 12'd2016;
  localparam logic [LevelBits-1:0]    WhiteLevelReset = 12'd4032;

  typedef enum logic [1:0] {
    REG_ROW_WIDTH   = 2'd0,
    REG_THRESHOLD   = 2'd1,
    REG_WHITE_LEVEL = 2'd2
  } reg_idx_e;

  typedef logic signed [ErrBits-1:0] err_t;

endpackage

### hw/rtl/error_diffusion_dither_top.sv
`timescale 1ns / 1ps

// channel     | direction | payload
// ------------+-----------+---------------------------------------------------
// s_axis      | in        | tdata: pixel; tuser: frame_start
// m_axis      | out       | tdata: black, level; tlast: row_last
// apb         | in        | row_width @0x0, threshold @0x4, white_level @0x8
//
// one pixel per clock sustained while m_axis_tready holds; a pixel goes from request to result via
// the input stage (registers it, reads error line ram), then diffuses into the result register.
// the error line ram is written for a pixel as its result is registered.
// reset clears control and error state; the error line holds garbage until written.
// a stalled result holds in the output register while one more pixel waits in the input stage.

module error_diffusion_dither_top #(
  parameter int MAX_WIDTH  = 512,
  parameter int PIXEL_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // apb configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // pixel stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0] s_axis_tdata,  // [PIXEL_BITS-1:0] pixel
  input  logic                           s_axis_tuser,  // [0] frame_start
  // decision stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // [0] black, [12:1] level
  output logic                           m_axis_tlast   // row_last
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CW  = ((AW + 1) > edd_pkg::RowWidthBits) ? (AW + 1) : edd_pkg::RowWidthBits;
  localparam int VW  = ((PIXEL_BITS > edd_pkg::ErrBits) ? PIXEL_BITS : edd_pkg::ErrBits) + 3;
  localparam int SW  = VW + 4;
  localparam int LB  = edd_pkg::LevelBits;

  function automatic edd_pkg::err_t sat_err(input logic signed [SW-1:0] x);
    edd_pkg::err_t r;
    if (x > SW'(edd_pkg::ErrMax)) begin
      r = edd_pkg::err_t'(edd_pkg::ErrMax);
    end else if (x < SW'(edd_pkg::ErrMin)) begin
      r = edd_pkg::err_t'(edd_pkg::ErrMin);
    end else begin
      r = x[edd_pkg::ErrBits-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [edd_pkg::RowWidthBits-1:0] row_width_q;
  logic [LB-1:0]                    threshold_q;
  logic [LB-1:0]                    white_level_q;
  logic                             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q   <= edd_pkg::RowWidthReset;
      threshold_q   <= edd_pkg::ThresholdReset;
      white_level_q <= edd_pkg::WhiteLevelReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        edd_pkg::REG_ROW_WIDTH:   row_width_q   <= pwdata[edd_pkg::RowWidthBits-1:0];
        edd_pkg::REG_THRESHOLD:   threshold_q   <= pwdata[LB-1:0];
        edd_pkg::REG_WHITE_LEVEL: white_level_q <= pwdata[LB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      edd_pkg::REG_ROW_WIDTH:   prdata = 32'(row_width_q);
      edd_pkg::REG_THRESHOLD:   prdata = 32'(threshold_q);
      edd_pkg::REG_WHITE_LEVEL: prdata = 32'(white_level_q);
      default:                  prdata = 32'd0;
    endcase
  end

  // effective width and last column
  logic [CW-1:0] rw_ext;
  logic [CW-1:0] w_clamp;
  logic [AW-1:0] last_idx;

  assign rw_ext = CW'(row_width_q);

  always_comb begin
    if (rw_ext < CW'(edd_pkg::MinRowWidth)) begin
      w_clamp = CW'(edd_pkg::MinRowWidth);
    end else if (rw_ext > CW'(MAX_WIDTH)) begin
      w_clamp = CW'(MAX_WIDTH);
    end else begin
      w_clamp = rw_ext;
    end
  end

  assign last_idx = AW'(w_clamp - CW'(1));

  // handshake
  logic in_accept;
  logic s1_valid_q;
  logic s1_move;
  logic out_valid_q;

  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // column tracking at request time
  logic [AW-1:0] column_q;
  logic          first_row_q;
  logic [AW-1:0] col_base;
  logic [AW-1:0] col_in;
  logic          last_in;
  logic          first_in;

  assign col_base = s_axis_tuser ? '0 : column_q;
  assign col_in   = (col_base >= last_idx) ? last_idx : col_base;
  assign last_in  = (col_in == last_idx);
  assign first_in = s_axis_tuser || first_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      first_row_q <= 1'b1;
      s1_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_accept || (s1_valid_q && !s1_move);
      if (in_accept) begin
        column_q    <= last_in ? '0 : col_in + AW'(1);
        first_row_q <= last_in ? 1'b0 : first_in;
      end
    end
  end

  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic [AW-1:0]         s1_col_q;
  logic                  s1_last_q;
  logic                  s1_first_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q   <= s_axis_tdata[PIXEL_BITS-1:0];
      s1_col_q   <= col_in;
      s1_last_q  <= last_in;
      s1_first_q <= first_in;
    end
  end

  // error line
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [edd_pkg::ErrBits-1:0] ram_wdata;
  logic [edd_pkg::ErrBits-1:0] ram_rdata;

  edd_ram #(
    .WIDTH(edd_pkg::ErrBits),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_accept),
    .raddr_i(col_in),
    .rdata_o(ram_rdata)
  );

  // diffusion state
  edd_pkg::err_t right_err_q;
  edd_pkg::err_t pend_bl_q;
  edd_pkg::err_t pend_b_q;
  logic          zero_pend_q;
  logic [AW-1:0] zero_addr_q;

  logic                   col_zero;
  logic                   col_one;
  logic                   edge_col;
  logic signed [VW-1:0]   below_x;
  logic signed [VW-1:0]   v;
  logic signed [VW-1:0]   thr_x;
  logic                   blk;
  logic [LB-1:0]          lvl;
  logic signed [SW-1:0]   e;
  logic signed [SW-1:0]   e3;
  logic signed [SW-1:0]   e5;
  logic signed [SW-1:0]   e7;
  logic signed [SW-1:0]   sum_bl_w;
  logic signed [SW-1:0]   sum_pbl;
  logic signed [SW-1:0]   q1;
  logic signed [SW-1:0]   q7;

  assign col_zero = (s1_col_q == '0);
  assign col_one  = (s1_col_q == AW'(1));
  assign edge_col = col_zero || s1_last_q;

  assign below_x = s1_first_q ? '0 : VW'($signed(ram_rdata));
  assign v       = VW'(s1_pix_q) + VW'(right_err_q) + below_x;
  assign thr_x   = VW'(threshold_q);
  assign blk     = !edge_col && (v < thr_x);
  assign lvl     = blk ? '0 : white_level_q;

  assign e  = SW'(v) - SW'(lvl);
  assign e3 = (e <<< 1) + e;
  assign e5 = (e <<< 2) + e;
  assign e7 = (e <<< 3) - e;

  assign sum_bl_w = SW'(pend_bl_q) + (e3 >>> 4);
  assign sum_pbl  = SW'(pend_b_q) + (e5 >>> 4);
  assign q1       = e >>> 4;
  assign q7       = e7 >>> 4;

  // the last column's own entry is zeroed on the following column-zero pixel
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_col_q - AW'(1);
    ram_wdata = '0;
    if (s1_move) begin
      if (col_zero) begin
        ram_we    = zero_pend_q;
        ram_waddr = zero_addr_q;
      end else if (s1_last_q) begin
        ram_we    = 1'b1;
        ram_wdata = pend_bl_q;
      end else if (!col_one) begin
        ram_we    = 1'b1;
        ram_wdata = sat_err(sum_bl_w);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_err_q <= '0;
      pend_bl_q   <= '0;
      pend_b_q    <= '0;
      zero_pend_q <= 1'b0;
      zero_addr_q <= '0;
    end else if (s1_move) begin
      if (edge_col) begin
        right_err_q <= '0;
        pend_bl_q   <= '0;
        pend_b_q    <= '0;
      end else begin
        right_err_q <= sat_err(q7);
        pend_bl_q   <= sat_err(sum_pbl);
        pend_b_q    <= sat_err(q1);
      end
      if (col_zero) begin
        zero_pend_q <= 1'b0;
      end else if (s1_last_q) begin
        zero_pend_q <= 1'b1;
        zero_addr_q <= s1_col_q;
      end
    end
  end

  // result register
  logic          out_black_q;
  logic [LB-1:0] out_level_q;
  logic          out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_black_q <= blk;
      out_level_q <= lvl;
      out_last_q  <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_level_q, out_black_q};
  assign m_axis_tlast  = out_last_q;

endmodule

### hw/rtl/edd_ram.sv
`timescale 1ns / 1ps

module edd_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
